### hdl/ratt_pkg.sv
// ratt_pkg: shared types and constants of the range alias translation table
// holds command and status codes, the entry layout and the control/status bundles
// no dependencies
package ratt_pkg;

    // field widths fixed by the interface
    localparam int ADDR_W   = 64;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FWD     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REV     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FLOOR = 3'd5;

    // reset value of the floor register
    localparam logic [ADDR_W-1:0] FLOOR_RESET = 64'h0000_0001_0000_0000;

    // one table entry as stored in the entry ram
    typedef struct packed {
        logic [ADDR_W-1:0] orig_base;
        logic [ADDR_W-1:0] alias_base;
        logic [ADDR_W-1:0] length;
    } entry_t;

    // what the current walk over the entries is looking for
    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_DUP,
        MODE_RET,
        MODE_FWD,
        MODE_REV
    } mode_t;

    // source of the result address
    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_ADDR,
        SEL_SUM
    } sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic                load;
        logic                scan_clr;
        logic                scan_en;
        mode_t               mode;
        logic                place;
        logic                sum;
        logic                out_load;
        sel_t                out_sel;
        logic [STATUS_W-1:0] out_status;
    } ctl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             below_floor;
        logic             match;
        logic             walk_done;
        logic             free_found;
        logic             full;
        logic             out_free;
    } dp_stat_t;

endpackage

### hdl/ratt_ram.sv
// ratt_ram: generic single write port, single read port ram with registered read
// used for the entry store of the translation table
// no dependencies
module ratt_ram #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 256
) (
    input  logic                                         aclk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/ratt_ctrl.sv
// ratt_ctrl: sequencing state machine of the translation table
// drives the datapath through the add passes and the lookup walk
// depends on ratt_pkg
module ratt_ctrl import ratt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_DUP,
        S_RET,
        S_PLACE,
        S_LOOK,
        S_SUM,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] code_reg, code_next;
    sel_t                sel_reg, sel_next;
    mode_t               look_mode_reg, look_mode_next;

    assign s_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        code_next      = code_reg;
        sel_next       = sel_reg;
        look_mode_next = look_mode_reg;
        cmd            = '0;
        cmd.mode       = MODE_NONE;
        cmd.out_sel    = sel_reg;
        cmd.out_status = code_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (stat.cmd)
                    CMD_ADD: begin
                        if (stat.below_floor) begin
                            code_next  = ST_FLOOR;
                            sel_next   = SEL_ZERO;
                            state_next = S_RESP;
                        end else begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_DUP;
                        end
                    end
                    CMD_FWD, CMD_REV: begin
                        cmd.scan_clr   = 1'b1;
                        look_mode_next = (stat.cmd == CMD_FWD) ? MODE_FWD : MODE_REV;
                        state_next     = S_LOOK;
                    end
                    default: begin
                        code_next  = ST_MISS;
                        sel_next   = SEL_ADDR;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_DUP: begin
                cmd.scan_en = 1'b1;
                cmd.mode    = MODE_DUP;
                if (stat.match) begin
                    code_next  = ST_DUP;
                    sel_next   = SEL_ZERO;
                    state_next = S_RESP;
                end else if (stat.walk_done) begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_RET;
                end
            end
            S_RET: begin
                cmd.scan_en = 1'b1;
                cmd.mode    = MODE_RET;
                if (stat.walk_done) begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                cmd.place  = 1'b1;
                code_next  = (stat.free_found || !stat.full) ? ST_ADDED : ST_FULL;
                sel_next   = SEL_ZERO;
                state_next = S_RESP;
            end
            S_LOOK: begin
                cmd.scan_en = 1'b1;
                cmd.mode    = look_mode_reg;
                if (stat.match) begin
                    state_next = S_SUM;
                end else if (stat.walk_done) begin
                    code_next  = ST_MISS;
                    sel_next   = SEL_ADDR;
                    state_next = S_RESP;
                end
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                code_next  = ST_HIT;
                sel_next   = SEL_SUM;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            code_reg      <= ST_MISS;
            sel_reg       <= SEL_ZERO;
            look_mode_reg <= MODE_NONE;
        end else begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            sel_reg       <= sel_next;
            look_mode_reg <= look_mode_next;
        end
    end

endmodule

### hdl/ratt_dpath.sv
// ratt_dpath: datapath of the translation table
// holds the entry ram, the walk counters, the floor register and the result register
// depends on ratt_pkg and ratt_ram
module ratt_dpath import ratt_pkg::*; #(
    parameter int ENTRIES = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CMD_W-1:0]    s_command,
    input  logic [ADDR_W-1:0]   s_address,
    input  logic [ADDR_W-1:0]   s_alias_base,
    input  logic [ADDR_W-1:0]   s_region_size,
    input  logic                cfg_valid,
    input  logic [ADDR_W-1:0]   cfg_floor_address,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ADDR_W-1:0]   m_result_address,
    output logic [STATUS_W-1:0] m_status,
    input  ctl_cmd_t            cmd,
    output dp_stat_t            stat
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = $bits(entry_t);

    // captured item and configuration
    logic [ADDR_W-1:0]   floor_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   ab_reg;
    logic [ADDR_W-1:0]   len_reg;

    // walk and fill state
    logic [CW-1:0]       used_reg, used_next;
    logic [CW-1:0]       iss_reg, iss_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [IW-1:0]       pend_idx_reg;
    logic                free_vld_reg, free_vld_next;
    logic [IW-1:0]       free_idx_reg, free_idx_next;

    // hit and result
    logic [ADDR_W-1:0]   hit_base_reg;
    logic [ADDR_W-1:0]   hit_off_reg;
    logic [ADDR_W-1:0]   hit_res_reg;
    logic                m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]   m_addr_reg;
    logic [STATUS_W-1:0] m_status_reg;

    // ram ports
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    entry_t              wr_ent;
    logic                issue;
    logic [EW-1:0]       rd_data;
    entry_t              rd_ent;

    // compare terms
    logic [ADDR_W-1:0]   lk_base;
    logic [ADDR_W-1:0]   lk_other;
    logic [ADDR_W-1:0]   lk_diff;
    logic                lk_in;
    logic                dup_eq;
    logic [ADDR_W:0]     new_end;
    logic [ADDR_W:0]     old_end;
    logic                ovl;
    logic                hit;
    logic                full;
    logic                ret_wr;
    logic                place_wr;

    ratt_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_en   (issue),
        .rd_addr (iss_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    assign rd_ent = entry_t'(rd_data);
    assign full   = (used_reg == CW'(ENTRIES));
    assign issue  = cmd.scan_en && !cmd.scan_clr && (iss_reg < used_reg);

    // containment test for lookups, base picked by direction
    assign lk_base  = (cmd.mode == MODE_REV) ? rd_ent.alias_base : rd_ent.orig_base;
    assign lk_other = (cmd.mode == MODE_REV) ? rd_ent.orig_base : rd_ent.alias_base;
    assign lk_diff  = addr_reg - lk_base;
    assign lk_in    = (addr_reg >= lk_base) && (lk_diff < rd_ent.length);

    // exact duplicate test
    assign dup_eq = (rd_ent.orig_base == addr_reg) && (rd_ent.alias_base == ab_reg)
                 && (rd_ent.length == len_reg);

    // overlap test with 65 bit range ends
    assign new_end = {1'b0, addr_reg} + {1'b0, len_reg};
    assign old_end = {1'b0, rd_ent.orig_base} + {1'b0, rd_ent.length};
    assign ovl     = (rd_ent.length != '0) && ({1'b0, rd_ent.orig_base} < new_end)
                  && ({1'b0, addr_reg} < old_end);

    // match on the entry whose read data is present
    always_comb begin
        case (cmd.mode)
            MODE_DUP:          hit = dup_eq;
            MODE_RET:          hit = ovl;
            MODE_FWD, MODE_REV: hit = lk_in;
            default:           hit = 1'b0;
        endcase
    end

    // entry writes: retire in place, or place the new entry
    assign ret_wr   = (cmd.mode == MODE_RET) && pend_vld_reg && ovl;
    assign place_wr = cmd.place && (free_vld_reg || !full);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pend_idx_reg;
        wr_ent  = '{orig_base: addr_reg, alias_base: ab_reg, length: len_reg};
        if (ret_wr) begin
            wr_en  = 1'b1;
            wr_ent = '{orig_base: rd_ent.orig_base, alias_base: rd_ent.alias_base,
                       length: '0};
        end else if (place_wr) begin
            wr_en   = 1'b1;
            wr_addr = free_vld_reg ? free_idx_reg : used_reg[IW-1:0];
        end
    end

    // walk counter, pending read and first free slot
    always_comb begin
        iss_next      = iss_reg;
        pend_vld_next = issue;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        used_next     = used_reg;
        if (cmd.scan_clr) begin
            iss_next      = '0;
            free_vld_next = 1'b0;
        end else if (issue) begin
            iss_next = iss_reg + CW'(1);
        end
        if (!cmd.scan_clr && (cmd.mode == MODE_RET) && pend_vld_reg && !free_vld_reg
            && ((rd_ent.length == '0) || ovl)) begin
            free_vld_next = 1'b1;
            free_idx_next = pend_idx_reg;
        end
        if (cmd.place && !free_vld_reg && !full) begin
            used_next = used_reg + CW'(1);
        end
    end

    // result beat holding register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg    <= FLOOR_RESET;
            used_reg     <= '0;
            iss_reg      <= '0;
            pend_vld_reg <= 1'b0;
            free_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                floor_reg <= cfg_floor_address;
            end
            used_reg     <= used_next;
            iss_reg      <= iss_next;
            pend_vld_reg <= pend_vld_next;
            free_vld_reg <= free_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg  <= s_command;
            addr_reg <= s_address;
            ab_reg   <= s_alias_base;
            len_reg  <= s_region_size;
        end
        if (issue) begin
            pend_idx_reg <= iss_reg[IW-1:0];
        end
        free_idx_reg <= free_idx_next;
        if (pend_vld_reg && hit && ((cmd.mode == MODE_FWD) || (cmd.mode == MODE_REV))) begin
            hit_base_reg <= lk_other;
            hit_off_reg  <= lk_diff;
        end
        if (cmd.sum) begin
            hit_res_reg <= hit_base_reg + hit_off_reg;
        end
        if (cmd.out_load) begin
            m_status_reg <= cmd.out_status;
            case (cmd.out_sel)
                SEL_ADDR: m_addr_reg <= addr_reg;
                SEL_SUM:  m_addr_reg <= hit_res_reg;
                default:  m_addr_reg <= '0;
            endcase
        end
    end

    // status toward the controller
    assign stat.cmd         = cmd_reg;
    assign stat.below_floor = (addr_reg < floor_reg);
    assign stat.match       = pend_vld_reg && hit;
    assign stat.walk_done   = !pend_vld_reg && (iss_reg == used_reg);
    assign stat.free_found  = free_vld_reg;
    assign stat.full        = full;
    assign stat.out_free    = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_result_address = m_addr_reg;
    assign m_status         = m_status_reg;

endmodule

### hdl/range_alias_translation_table.sv
// Range alias translation table. Holds up to ENTRIES (original base, alias base,
// size) entries in one entry ram and serves one command at a time: add, translate
// original to alias, and reverse. A lookup walks the used entries in index order at
// one entry per clock, limited by the single read port of the entry ram; an add walks
// the table twice (duplicate check, then overlap retire). The result sits in an output
// register, so the next item is taken while the previous result waits. The floor
// register may be written at any idle time; cfg_ready is always high. No clearing pass
// runs after reset.
// depends on ratt_pkg, ratt_ctrl, ratt_dpath, ratt_ram
module range_alias_translation_table import ratt_pkg::*; #(
    parameter int ENTRIES = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_command,
    input  logic [ADDR_W-1:0]   s_address,
    input  logic [ADDR_W-1:0]   s_alias_base,
    input  logic [ADDR_W-1:0]   s_region_size,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ADDR_W-1:0]   m_result_address,
    output logic [STATUS_W-1:0] m_status,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ADDR_W-1:0]   cfg_floor_address
);

    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;

    assign cfg_ready = 1'b1;

    // sequencer
    ratt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (dp_stat),
        .cmd     (ctl_cmd)
    );

    // storage and compare datapath
    ratt_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_command         (s_command),
        .s_address         (s_address),
        .s_alias_base      (s_alias_base),
        .s_region_size     (s_region_size),
        .cfg_valid         (cfg_valid),
        .cfg_floor_address (cfg_floor_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_address  (m_result_address),
        .m_status          (m_status),
        .cmd               (ctl_cmd),
        .stat              (dp_stat)
    );

endmodule

### hdl/ratt_checker.sv
// ratt_checker: port level checks of the translation table, bound to the top level
// watches the input and result channels over time
// depends on ratt_pkg and range_alias_translation_table
module ratt_checker import ratt_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [ADDR_W-1:0]   m_result_address,
    input logic [STATUS_W-1:0] m_status
);

    // result beat holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_address) && $stable(m_status))
        else $error("result beat changed while stalled");

    // only one item in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in flight");

    // status stays within defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_FLOOR)
        else $error("undefined status code");

    // add outcomes carry a zero address
    a_add_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_ADDED || m_status == ST_DUP || m_status == ST_FULL
                    || m_status == ST_FLOOR) |-> m_result_address == '0)
        else $error("add result with nonzero address");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind range_alias_translation_table ratt_checker u_ratt_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_result_address (m_result_address),
    .m_status         (m_status)
);
